### hw/rtl/lte_pkg.sv
// lte_pkg: shared constants and types for the LSB tag extractor.
// Used by lte_scan and lsb_tag_extractor; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lte_pkg;

  // Frame length in samples (one tag bit per sample)
  localparam int TAG_BITS = 16;
  // Minimum buffer length in samples for a valid result
  localparam int MIN_LEN  = 32;

  localparam int POS_W = $clog2(TAG_BITS);
  localparam int LEN_W = $clog2(MIN_LEN + 1);

  // Sync word, cut or zero-extended to the frame width
  localparam logic [TAG_BITS-1:0] SYNC_WORD = TAG_BITS'(32'h0000_7FFE);

  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(TAG_BITS - 1);
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MIN_LEN);

  // Scan phase codes
  localparam logic [1:0] PH_SEARCH  = 2'd0;
  localparam logic [1:0] PH_CAPTURE = 2'd1;
  localparam logic [1:0] PH_DONE    = 2'd2;

  // One accepted sample, reduced to what the scan needs
  typedef struct packed {
    logic lsb;
    logic last;
  } lte_item_t;

  // One result word
  typedef struct packed {
    logic        status;
    logic [15:0] tag;
    logic        found;
  } lte_result_t;

endpackage

`default_nettype wire

### hw/rtl/lte_scan.sv
// lte_scan: frame LSB collection, sync search and tag capture for one buffer.
// Depends on lte_pkg. Consumes one item per cycle when step is high.
`timescale 1ns / 1ps
`default_nettype none

module lte_scan
  import lte_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire lte_item_t   item,
  output lte_result_t      result,
  output logic             result_valid
);

  logic [TAG_BITS-1:0] lsb_shift, lsb_shift_next;
  logic [POS_W-1:0]    bit_position, bit_position_next;
  logic [1:0]          phase, phase_next;
  logic [LEN_W-1:0]    length_count, length_count_next;

  logic [TAG_BITS-1:0] gathered;
  logic [31:0]         tag_wide;

  // Next scan state for the item at hand
  always_comb begin
    gathered                = lsb_shift;
    gathered[bit_position]  = item.lsb;
    lsb_shift_next          = lsb_shift;
    bit_position_next       = bit_position;
    phase_next              = phase;
    length_count_next       = length_count;

    if (length_count < LEN_LIMIT) begin
      length_count_next = length_count + LEN_W'(1);
    end

    if (phase != PH_DONE) begin
      if (bit_position == POS_LAST) begin
        bit_position_next = '0;
        if (phase == PH_SEARCH) begin
          lsb_shift_next = '0;
          if (gathered == SYNC_WORD) begin
            phase_next = PH_CAPTURE;
          end
        end else begin
          lsb_shift_next = gathered;
          phase_next     = PH_DONE;
        end
      end else begin
        bit_position_next = bit_position + POS_W'(1);
        lsb_shift_next    = gathered;
      end
    end
  end

  // Result for a last sample, from the updated state
  always_comb begin
    tag_wide      = 32'(lsb_shift_next);
    result.status = (length_count_next < LEN_LIMIT);
    result.found  = !result.status && (phase_next != PH_SEARCH);
    result.tag    = (!result.status && (phase_next == PH_DONE)) ? tag_wide[15:0] : 16'd0;
  end

  assign result_valid = step && item.last;

  // State update; a last sample returns the scan to its reset state
  always_ff @(posedge clk) begin
    if (rst || (step && item.last)) begin
      lsb_shift    <= '0;
      bit_position <= '0;
      phase        <= PH_SEARCH;
      length_count <= '0;
    end else if (step) begin
      lsb_shift    <= lsb_shift_next;
      bit_position <= bit_position_next;
      phase        <= phase_next;
      length_count <= length_count_next;
    end
  end

  // A short buffer never reports a tag
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status) |-> (!result.found && result.tag == 16'd0))
    else $error("short buffer reported found or tag");

  // A nonzero tag requires a finished capture
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.tag != 16'd0) |-> result.found)
    else $error("tag without found");

  // After a last sample the scan is back at its start
  assert property (@(posedge clk) disable iff (rst)
    result_valid |=> (phase == PH_SEARCH && bit_position == '0 && length_count == '0))
    else $error("scan state not cleared after buffer end");

  // The frame bit index stays inside the frame
  assert property (@(posedge clk) disable iff (rst)
    bit_position <= POS_LAST)
    else $error("bit position out of frame");

endmodule

`default_nettype wire

### hw/rtl/lsb_tag_extractor.sv
// lsb_tag_extractor: top level with input register, scan core and output register.
// Depends on lte_pkg and lte_scan.
//
// Reads a buffer of 16-bit samples, one word per cycle, ended by tlast. The LSBs
// of each aligned 16-sample frame form a word (first sample in bit 0); the frame
// after the first one equal to 0x7FFE holds the tag. One result word comes out
// for each tlast: found, tag and a short-buffer status (fewer than 32 samples).
// The block takes one sample per cycle while the input is not stalled; a sample passes
// the input register and the scan update, and a result is held in the output register
// until it is taken. Only a held result stalls the input, and only when the
// next last sample reaches the scan.
`timescale 1ns / 1ps
`default_nettype none

module lsb_tag_extractor
  import lte_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Sample stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] sample (signed)
  input  wire logic        s_tlast,   // last sample of the buffer
  // Result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [15:0] tag
  output logic [1:0]       m_tuser    // [0] found, [1] status
);

  logic        in_valid;
  lte_item_t   in_item;
  logic        advance;
  lte_result_t scan_result;
  logic        scan_result_valid;
  lte_result_t out_result;

  // Input register moves on unless a result would meet a full output register
  assign advance  = in_valid && (!in_item.last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.lsb  <= s_tdata[0];
      in_item.last <= s_tlast;
    end
  end

  // Scan core
  lte_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .item         (in_item),
    .result       (scan_result),
    .result_valid (scan_result_valid)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (scan_result_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_result_valid) begin
      out_result <= scan_result;
    end
  end

  assign m_tdata    = out_result.tag;
  assign m_tuser[0] = out_result.found;
  assign m_tuser[1] = out_result.status;

endmodule

`default_nettype wire

### tb/sv/tb.sv
// tb: self-checking testbench for lsb_tag_extractor (sync word search and tag capture).
// Depends on lte_pkg and the lsb_tag_extractor RTL; drives random stream stalls on both sides.
`timescale 1ns / 1ps

module tb;
  import lte_pkg::*;

  localparam int RAND_ITEMS  = 960;
  localparam int RAND_BUFS   = 15;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_WAIT  = 8;
  localparam int LONG_HOLD   = 300;
  localparam int PRINT_LIMIT = 100;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;

  lsb_tag_extractor dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [15:0] sample
    .s_tlast  (s_tlast),   // last sample of the buffer
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [15:0] tag
    .m_tuser  (m_tuser)    // [0] found, [1] status
  );

  // Scan state mirrored by the predictor
  logic [TAG_BITS-1:0] frame_bits = '0;
  int                  frame_pos  = 0;
  logic [1:0]          scan_phase = PH_SEARCH;
  int                  seen_count = 0;

  lte_result_t tag_expect_q[$];
  bit          buf_bits[$];

  int fail_count  = 0;
  int item_count  = 0;
  int buf_count   = 0;
  bit tx_quiet    = 1'b0;
  bit rx_quiet    = 1'b0;
  int rx_hold_req = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report(input string msg);
    if (fail_count < PRINT_LIMIT) $display("tb: mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Advance the mirrored scan by one sample; queue the result on the last one
  task automatic predict_sample(input logic lsb, input logic lst);
    lte_result_t res;
    if (seen_count < MIN_LEN) seen_count++;
    if (scan_phase != PH_DONE) begin
      frame_bits[frame_pos] = lsb;
      if (frame_pos == TAG_BITS - 1) begin
        frame_pos = 0;
        if (scan_phase == PH_SEARCH) begin
          if (frame_bits == SYNC_WORD) scan_phase = PH_CAPTURE;
          frame_bits = '0;
        end else begin
          // frame_bits now holds the tag
          scan_phase = PH_DONE;
        end
      end else begin
        frame_pos++;
      end
    end
    if (lst) begin
      res.status = (seen_count < MIN_LEN);
      res.found  = !res.status && (scan_phase != PH_SEARCH);
      res.tag    = (!res.status && scan_phase == PH_DONE) ? 16'(frame_bits) : 16'h0000;
      tag_expect_q.push_back(res);
      frame_bits = '0;
      frame_pos  = 0;
      scan_phase = PH_SEARCH;
      seen_count = 0;
    end
  endtask

  // Offer one sample word and wait for it to be taken
  task automatic send_sample(input logic [15:0] smp, input logic lst);
    int gap;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    predict_sample(smp[0], lst);
    item_count++;
  endtask

  // Send the LSB pattern in buf_bits as one buffer, upper bits random
  task automatic send_buffer();
    int n;
    if (buf_bits.size() == 0) buf_bits.push_back(1'($urandom));
    n = buf_bits.size();
    for (int i = 0; i < n; i++) send_sample({15'($urandom), buf_bits[i]}, i == n - 1);
    buf_bits.delete();
    buf_count++;
  endtask

  task automatic add_word(input logic [TAG_BITS-1:0] w);
    for (int i = 0; i < TAG_BITS; i++) buf_bits.push_back(w[i]);
  endtask

  task automatic add_noise(input int n);
    for (int i = 0; i < n; i++) buf_bits.push_back(1'($urandom));
  endtask

  function automatic logic [TAG_BITS-1:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return TAG_BITS'($urandom);
  endfunction

  // Result side: check taken words, then pick next tready
  initial begin : result_sink
    int          stall_left;
    lte_result_t exp_res;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (tag_expect_q.size() == 0) begin
          report($sformatf("unexpected result tag=%h user=%b", m_tdata, m_tuser));
        end else begin
          exp_res = tag_expect_q.pop_front();
          if (m_tuser[0] !== exp_res.found)
            report($sformatf("found %b, expected %b", m_tuser[0], exp_res.found));
          if (m_tdata !== exp_res.tag)
            report($sformatf("tag %h, expected %h", m_tdata, exp_res.tag));
          if (m_tuser[1] !== exp_res.status)
            report($sformatf("status %b, expected %b", m_tuser[1], exp_res.status));
        end
      end
      if (rx_hold_req > 0) begin
        stall_left  = rx_hold_req;
        rx_hold_req = 0;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (rx_quiet) begin
        m_tready <= 1'b1;
      end else begin
        stall_left = pick_gap(1'b0);
        if (stall_left == 0) begin
          m_tready <= 1'b1;
        end else begin
          m_tready <= 1'b0;
          stall_left--;
        end
      end
    end
  end

  // Give up after a long run of cycles with no word moving on either side
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // Single-sample buffers at the sample extremes: all short
  task automatic test_extremes();
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0000, 1'b1);
    buf_count += 4;
  endtask

  // Sync frame first, tag right after it
  task automatic test_sync_and_tag();
    add_word(SYNC_WORD);
    add_word(TAG_BITS'(32'h8001));
    send_buffer();
    add_word(SYNC_WORD);
    add_word('1);
    send_buffer();
  endtask

  // Sync in the last complete frame: found with a zero tag
  task automatic test_sync_in_final_frame();
    add_word(TAG_BITS'(32'h1234));
    add_word(SYNC_WORD);
    send_buffer();
  endtask

  // Short buffer that holds a sync frame: status set, nothing found
  task automatic test_short_with_sync();
    add_word(SYNC_WORD);
    add_noise(MIN_LEN - 1 - TAG_BITS);
    send_buffer();
  endtask

  // No sync at all, with LSBs all ones and all zeros
  task automatic test_no_sync();
    add_word('1);
    add_word('1);
    send_buffer();
    add_word('0);
    add_word('0);
    add_word('0);
    send_buffer();
  endtask

  // Trailing partial frame is ignored
  task automatic test_partial_tail();
    add_word(SYNC_WORD);
    add_word(TAG_BITS'(32'h5A5A));
    add_noise(7);
    send_buffer();
    add_word(TAG_BITS'(32'h0F0F));
    add_word(SYNC_WORD);
    add_noise(TAG_BITS - 1);
    send_buffer();
  endtask

  // Sync pattern off the frame grid must not match
  task automatic test_misaligned_sync();
    add_noise(0);
    for (int i = 0; i < TAG_BITS / 2; i++) buf_bits.push_back(1'b0);
    add_word(SYNC_WORD);
    add_word(TAG_BITS'(32'hA5C3));
    for (int i = 0; i < TAG_BITS / 2; i++) buf_bits.push_back(1'b1);
    send_buffer();
  endtask

  // Only the first sync counts; a sync word right after it is the tag
  task automatic test_repeated_sync();
    add_word(SYNC_WORD);
    add_word(SYNC_WORD);
    add_word(SYNC_WORD);
    send_buffer();
    add_word(TAG_BITS'(32'hBEEF));
    add_word(SYNC_WORD);
    add_word(TAG_BITS'(32'h0001));
    add_word(SYNC_WORD);
    send_buffer();
  endtask

  // Receiver stalls for a long stretch while short buffers keep coming
  task automatic test_backpressure();
    tx_quiet    = 1'b1;
    rx_hold_req = LONG_HOLD;
    for (int i = 0; i < 12; i++) begin
      add_noise($urandom_range(1, 4));
      send_buffer();
    end
    tx_quiet = 1'b0;
  endtask

  // Mostly well-formed buffers with random content, some short or pure noise
  task automatic test_random();
    int first_item;
    int first_buf;
    int r;
    first_item = item_count;
    first_buf  = buf_count;
    while (item_count - first_item < RAND_ITEMS || buf_count - first_buf < RAND_BUFS) begin
      if ($urandom_range(0, 4) == 0) tx_quiet = !tx_quiet;
      if ($urandom_range(0, 4) == 0) rx_quiet = !rx_quiet;
      r = $urandom_range(0, 99);
      if (r < 15) begin
        add_noise($urandom_range(1, 100));
      end else if (r < 25) begin
        add_word(SYNC_WORD);
        add_word(rand_word());
        while (buf_bits.size() > $urandom_range(1, MIN_LEN - 1)) void'(buf_bits.pop_back());
      end else begin
        repeat ($urandom_range(0, 2)) add_word(rand_word());
        if ($urandom_range(0, 99) < 85) begin
          add_word(SYNC_WORD);
          if ($urandom_range(0, 9) != 0) add_word(rand_word());
        end
        repeat ($urandom_range(0, 1)) add_word(rand_word());
        add_noise($urandom_range(0, TAG_BITS - 1));
      end
      send_buffer();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin : main
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_sync_and_tag();
    test_sync_in_final_frame();
    test_short_with_sync();
    test_no_sync();
    test_partial_tail();
    test_misaligned_sync();
    test_repeated_sync();
    test_backpressure();
    test_random();
    s_tvalid <= 1'b0;
    while (tag_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
